// File: rtl/core/icymsd_pkg.sv
// Package with shared types and constants of the interval metadata demultiplexer.
`timescale 1ns / 1ps

package icymsd_pkg;

  // Field widths.
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 24;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  // Each unit of the length byte stands for this many metadata bytes.
  localparam int META_BLOCK_UNIT = 16;
  localparam int BLK_SHIFT       = $clog2(META_BLOCK_UNIT);

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_META_INTERVAL    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FORWARD_METADATA = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPTURE_ENABLE   = 2'd2;

  // Stream phase. Phase code three never occurs; it would read as audio.
  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_META  = 2'd2
  } phase_t;

  // Tag carried with every output byte.
  typedef enum logic [1:0] {
    KIND_AUDIO  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_META   = 2'd2
  } kind_t;

  // Configuration register contents.
  typedef struct packed {
    logic [CNT_W-1:0] meta_interval;
    logic             forward_metadata;
    logic             capture_enable;
  } cfg_t;

  // One tagged result beat.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    kind_t             byte_kind;
    logic              forward;
    logic              capture;
    logic              metadata_end;
  } result_t;

endpackage

// File: rtl/core/icymsd_ifs.sv
// Stream and configuration channel interfaces of the demultiplexer.
`timescale 1ns / 1ps

interface icymsd_in_if;
  import icymsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface icymsd_out_if;
  import icymsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [1:0]        byte_kind;
  logic              forward;
  logic              capture;
  logic              metadata_end;

  modport source (output valid, output out_byte, output byte_kind, output forward,
                  output capture, output metadata_end, input ready);
  modport sink (input valid, input out_byte, input byte_kind, input forward,
                input capture, input metadata_end, output ready);
endinterface

interface icymsd_cfg_if;
  import icymsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

// File: rtl/core/icymsd_cfg_regs.sv
// Configuration registers written through the configuration channel.
`timescale 1ns / 1ps

module icymsd_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  icymsd_cfg_if.sink      cfg_chan,
  output icymsd_pkg::cfg_t cfg
);
  import icymsd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_chan.ready = 1'b1;
  assign wr_en          = cfg_chan.valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_chan.addr)
        REG_META_INTERVAL:    cfg_nxt.meta_interval    = cfg_chan.wdata[CNT_W-1:0];
        REG_FORWARD_METADATA: cfg_nxt.forward_metadata = cfg_chan.wdata[0];
        REG_CAPTURE_ENABLE:   cfg_nxt.capture_enable   = cfg_chan.wdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/icymsd_in_reg.sv
// Input register stage holding one raw stream byte.
`timescale 1ns / 1ps

module icymsd_in_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  icymsd_in_if.sink                        in_chan,
  input  logic                             space,
  output logic                             s1_valid,
  output logic [icymsd_pkg::BYTE_W-1:0]    s1_byte
);
  import icymsd_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              take;

  // The stage refills whenever it is empty or drains in this cycle.
  assign in_chan.ready = !valid_r || space;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (space) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_chan.data_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

// File: rtl/core/icymsd_core.sv
// Phase and byte counter logic that tags each stream byte.
`timescale 1ns / 1ps

module icymsd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  icymsd_pkg::cfg_t              cfg,
  input  logic                          fire,
  input  logic [icymsd_pkg::BYTE_W-1:0] s1_byte,
  output icymsd_pkg::result_t           res
);
  import icymsd_pkg::*;

  phase_t           phase_r;
  phase_t           phase_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_dec;
  kind_t            kind;
  logic             meta_end;

  // Metadata countdown stops at zero.
  assign count_dec = (count_r != '0) ? count_r - CNT_W'(1) : '0;

  // Next phase and count for the byte in the input stage.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    kind      = KIND_AUDIO;
    meta_end  = 1'b0;
    if (cfg.meta_interval == '0) begin
      // Demultiplexing is off: every byte is audio.
      phase_nxt = PH_AUDIO;
      count_nxt = '0;
    end else if (phase_r == PH_META) begin
      kind      = KIND_META;
      count_nxt = count_dec;
      if (count_dec == '0) begin
        meta_end  = 1'b1;
        phase_nxt = PH_AUDIO;
      end
    end else if (count_r >= cfg.meta_interval) begin
      // Interval reached, so this is the length byte.
      kind = KIND_LENGTH;
      if (s1_byte == '0) begin
        phase_nxt = PH_AUDIO;
        count_nxt = '0;
      end else begin
        phase_nxt = PH_META;
        count_nxt = CNT_W'(s1_byte) << BLK_SHIFT;
      end
    end else begin
      phase_nxt = PH_AUDIO;
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_AUDIO;
      count_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Result beat for the output register.
  always_comb begin
    res.out_byte     = s1_byte;
    res.byte_kind    = kind;
    res.forward      = (kind == KIND_AUDIO) ? 1'b1 : cfg.forward_metadata;
    res.capture      = (kind == KIND_AUDIO) ? cfg.capture_enable : 1'b0;
    res.metadata_end = meta_end;
  end

  // The metadata phase always has bytes left to count.
  a_meta_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_META |-> count_r != '0)
    else $error("metadata phase with zero byte count");

  // With demultiplexing off the state returns to audio with an empty count.
  a_interval_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cfg.meta_interval == '0 |=> phase_r == PH_AUDIO && count_r == '0)
    else $error("state not cleared with interval zero");

  // A nonzero length byte opens a block of sixteen bytes per unit.
  a_length_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && kind == KIND_LENGTH && s1_byte != '0
    |=> phase_r == PH_META && count_r == (CNT_W'($past(s1_byte)) << BLK_SHIFT))
    else $error("length byte did not load the metadata count");

endmodule

// File: rtl/core/icymsd_out_reg.sv
// Output register stage that holds one tagged result beat.
`timescale 1ns / 1ps

module icymsd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  icymsd_pkg::result_t res,
  icymsd_out_if.source        out_chan,
  output logic                space
);
  import icymsd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // The register can take a beat when empty or when its beat leaves now.
  assign space = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.out_byte     = res_r.out_byte;
  assign out_chan.byte_kind    = res_r.byte_kind;
  assign out_chan.forward      = res_r.forward;
  assign out_chan.capture      = res_r.capture;
  assign out_chan.metadata_end = res_r.metadata_end;

  // The end flag only ever marks a metadata byte.
  a_end_on_meta: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.metadata_end |-> res_r.byte_kind == KIND_META)
    else $error("metadata end flag on a non-metadata byte");

  // Capture applies to audio bytes only, and audio is always forwarded.
  a_capture_audio: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.capture |-> res_r.byte_kind == KIND_AUDIO && res_r.forward)
    else $error("capture flag on a non-audio byte");

endmodule

// File: rtl/core/icy_metadata_stream_demux_unit.sv
// Top level of the interval metadata demultiplexer.
//
//   Channel   Dir  Beat contents
//   in_chan   in   data_byte
//   out_chan  out  out_byte, byte_kind, forward, capture, metadata_end
//   cfg_chan  in   addr (register index), wdata
//
// One byte per cycle sustained while the output is not stalled; an accepted byte
// passes through the input register and then the output register to the output.
// The phase and byte counter update in the cycle a byte leaves the input register.
// A stall on the output holds both stages; the input keeps taking beats while
// the input register has room.
// Synchronous active-low reset clears the valid flags, config, phase and counter.
`timescale 1ns / 1ps

module icy_metadata_stream_demux_unit (
  input  logic          clk,
  input  logic          rst_n,
  icymsd_in_if.sink     in_chan,
  icymsd_out_if.source  out_chan,
  icymsd_cfg_if.sink    cfg_chan
);
  import icymsd_pkg::*;

  cfg_t              cfg;
  logic              space;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              fire;
  result_t           res;

  // A byte moves on when the output register has room.
  assign fire = s1_valid && space;

  icymsd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  icymsd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .space    (space),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  icymsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (fire),
    .s1_byte (s1_byte),
    .res     (res)
  );

  icymsd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res      (res),
    .out_chan (out_chan),
    .space    (space)
  );

endmodule
